>>> rtl/sic_pkg.sv
// Shared types for the segment intersection classifier.
// Holds the result kind codes and the control bundle passed between pipeline parts.
// No dependencies.
package sic_pkg;

  typedef enum logic [2:0] {
    KIND_NONE           = 3'd0,
    KIND_SAME_LINE      = 3'd1,
    KIND_POINT_OVERLAP  = 3'd2,
    KIND_CONTAINS_POINT = 3'd3,
    KIND_INTERSECTION   = 3'd4,
    KIND_CONTAINS_LINE  = 3'd5,
    KIND_OVERLAP        = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  use_div;
  } sic_ctl_t;

endpackage

>>> rtl/segment_intersection_classifier_top.sv
// Top level of the segment intersection classifier: front pipeline, two dividers for
// the crossing point and the output register. Depends on sic_pkg, sic_front, sic_div.
//
//  Channel | Ports                      | Contents
//  input   | in_tvalid/tready/tdata     | two segments, eight signed coordinates
//  output  | out_tvalid/tready/tdata    | kind in tuser, four Q-format coordinates
//
// One pair enters per cycle while the output is not stalled; a result passes through
// seven front stages, one divider stage per quotient bit and one output register.
// Reset clears only the valid bits of every stage.
// A stall on the output freezes the whole pipeline at once; in_tready falls in the same cycle.
module segment_intersection_classifier_top
  import sic_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // seg_a_x1, seg_a_y1, seg_a_x2, seg_a_y2, seg_b_x1, seg_b_y1, seg_b_x2, seg_b_y2
  input  logic [8*COORD_BITS-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // first_x, first_y, second_x, second_y
  output logic [127:0]            out_tdata,
  // kind
  output logic [2:0]              out_tuser
);

  localparam int C   = COORD_BITS;
  localparam int DW  = 2 * C + 3;
  localparam int NW  = C + DW + 2;
  localparam int MW  = NW + FRAC_BITS;
  localparam int QW  = C + FRAC_BITS;
  localparam int EW  = (QW > 32) ? QW + 1 : 33;
  localparam int FW  = (C + FRAC_BITS + 1 > 33) ? C + FRAC_BITS + 1 : 33;
  localparam logic [EW-1:0]        Q_LIM   = EW'(64'h8000_0000);
  localparam logic signed [FW-1:0] FIX_MAX = FW'(64'sh7fff_ffff);
  localparam logic signed [FW-1:0] FIX_MIN = -FIX_MAX - FW'(1);

  logic en;

  logic              f_valid;
  sic_ctl_t          f_ctl;
  logic [3:0][C-1:0] f_pts;
  logic [MW-1:0]     f_magx, f_magy;
  logic              f_negx, f_negy;
  logic [DW-1:0]     f_den;
  logic [QW-1:0]     quo_x, quo_y;

  logic              sv_r   [QW];
  sic_ctl_t          sctl_r [QW];
  logic [3:0][C-1:0] spts_r [QW];
  logic              snx_r  [QW];
  logic              sny_r  [QW];

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [3:0][31:0]  out_pt_r;
  logic [3:0][31:0]  pt_nxt;

  function automatic logic [31:0] sat_quo(input logic [QW-1:0] q, input logic neg);
    logic [EW-1:0] qe;
    logic [EW-1:0] qn;
    qe = EW'(q);
    qn = EW'(0) - qe;
    if (neg) begin
      return (qe > Q_LIM) ? 32'h8000_0000 : qn[31:0];
    end
    return (qe >= Q_LIM) ? 32'h7fff_ffff : qe[31:0];
  endfunction

  function automatic logic [31:0] to_fix(input logic signed [C-1:0] c);
    logic signed [FW-1:0] v;
    v = FW'(c) <<< FRAC_BITS;
    if (v > FIX_MAX) begin
      return 32'h7fff_ffff;
    end
    if (v < FIX_MIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  sic_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .valid_o  (f_valid),
    .ctl_o    (f_ctl),
    .pts_o    (f_pts),
    .mag_x_o  (f_magx),
    .mag_y_o  (f_magy),
    .neg_x_o  (f_negx),
    .neg_y_o  (f_negy),
    .den_o    (f_den)
  );

  sic_div #(.DW(DW), .QW(QW)) u_div_x (
    .clk    (clk),
    .en     (en),
    .num_hi (f_magx[QW+DW-1:QW]),
    .num_lo (f_magx[QW-1:0]),
    .den    (f_den),
    .quo    (quo_x)
  );

  sic_div #(.DW(DW), .QW(QW)) u_div_y (
    .clk    (clk),
    .en     (en),
    .num_hi (f_magy[QW+DW-1:QW]),
    .num_lo (f_magy[QW-1:0]),
    .den    (f_den),
    .quo    (quo_y)
  );

  // Side information walks alongside the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (en) begin
      sv_r[0] <= f_valid;
      for (int k = 1; k < QW; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sctl_r[0] <= f_ctl;
      spts_r[0] <= f_pts;
      snx_r[0]  <= f_negx;
      sny_r[0]  <= f_negy;
      for (int k = 1; k < QW; k++) begin
        sctl_r[k] <= sctl_r[k-1];
        spts_r[k] <= spts_r[k-1];
        snx_r[k]  <= snx_r[k-1];
        sny_r[k]  <= sny_r[k-1];
      end
    end
  end

  always_comb begin
    if (sctl_r[QW-1].use_div) begin
      pt_nxt[0] = sat_quo(quo_x, snx_r[QW-1]);
      pt_nxt[1] = sat_quo(quo_y, sny_r[QW-1]);
      pt_nxt[2] = '0;
      pt_nxt[3] = '0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        pt_nxt[i] = to_fix(signed'(spts_r[QW-1][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r <= sctl_r[QW-1].kind;
      out_pt_r   <= pt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pt_r;
  assign out_tuser  = out_kind_r;

endmodule

>>> rtl/sic_front.sv
// Front pipeline of the segment intersection classifier: seven register stages that
// compute differences, cross products, the classification and the crossing numerators.
// Depends on sic_pkg.
module sic_front
  import sic_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [7:0][COORD_BITS-1:0]                    in_data,
  output logic                                          valid_o,
  output sic_ctl_t                                      ctl_o,
  output logic [3:0][COORD_BITS-1:0]                    pts_o,
  output logic [3*COORD_BITS+FRAC_BITS+4:0]             mag_x_o,
  output logic [3*COORD_BITS+FRAC_BITS+4:0]             mag_y_o,
  output logic                                          neg_x_o,
  output logic                                          neg_y_o,
  output logic [2*COORD_BITS+2:0]                       den_o
);

  localparam int C   = COORD_BITS;
  localparam int D1  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int DW  = 2 * C + 3;
  localparam int PXW = C + DW + 1;
  localparam int NW  = C + DW + 2;
  localparam int MW  = NW + FRAC_BITS;

  // Stage 1: registered input points.
  logic             v1_r;
  logic [7:0][C-1:0] p_r;
  logic signed [C-1:0] p [8];

  // Stage 1 combinational results.
  logic signed [D1-1:0] rx, ry, sx, sy, wx, wy;
  logic e02, e03, e12, e13, ax;
  logic signed [C-1:0] amaxx, aminx, amaxy, aminy, bmaxx, bminx, bmaxy, bminy;
  logic signed [C-1:0] ka0, ka1, kb0, kb1;
  logic a_swap, b_swap;

  // Stage 2 registers.
  logic              v2_r, same2_r, share2_r, kb2_r, dis2_r;
  logic [5:0][D1-1:0] d2_r;
  logic [3:0][C-1:0] pa2_r;
  logic [7:0][C-1:0] ord2_r;
  logic [3:0][C-1:0] key2_r;

  // Stage 2 combinational results.
  logic signed [C-1:0] as_k, ae_k, bs_k, be_k, lo, hi;
  logic s_is_a, e_is_a, whole;
  kind_t ck;
  logic [3:0][C-1:0] cp;
  logic [5:0][PW-1:0] m;

  // Stage 3 registers.
  logic              v3_r, same3_r, share3_r, kb3_r, dis3_r;
  logic [5:0][PW-1:0] m3_r;
  kind_t             ck3_r;
  logic [3:0][C-1:0] cp3_r, pa3_r;
  logic [D1-1:0]     rx3_r, ry3_r;

  logic signed [DW-1:0] den3, c13, c23;

  // Stage 4 registers.
  logic              v4_r, same4_r, share4_r, kb4_r, dis4_r;
  logic [DW-1:0]     den4_r, c14_r, c24_r;
  kind_t             ck4_r;
  logic [3:0][C-1:0] cp4_r, pa4_r;
  logic [D1-1:0]     rx4_r, ry4_r;

  logic signed [DW-1:0] den4s, c14s, c24s, dabs4, tn4, un4;
  logic dneg4;

  // Stage 5 registers.
  logic              v5_r, same5_r, share5_r, kb5_r, dis5_r, dz5_r, col5_r;
  logic [DW-1:0]     dabs5_r, tn5_r, un5_r;
  kind_t             ck5_r;
  logic [3:0][C-1:0] cp5_r, pa5_r;
  logic [D1-1:0]     rx5_r, ry5_r;

  logic signed [DW-1:0] dabs5, tn5, un5;
  logic in_rng, on_end;
  sic_ctl_t ctl5;
  logic [3:0][C-1:0] pts5;
  logic signed [PXW-1:0] mxa, mxb, mya, myb;

  // Stage 6 registers.
  logic              v6_r;
  sic_ctl_t          ctl6_r;
  logic [3:0][C-1:0] pts6_r;
  logic [PXW-1:0]    mxa6_r, mxb6_r, mya6_r, myb6_r;
  logic [DW-1:0]     dabs6_r;

  logic signed [NW-1:0] sumx6, sumy6;

  // Stage 7 registers.
  logic              v7_r;
  sic_ctl_t          ctl7_r;
  logic [3:0][C-1:0] pts7_r;
  logic [NW-1:0]     sumx7_r, sumy7_r;
  logic [DW-1:0]     dabs7_r;

  logic [NW-1:0] magx, magy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // ---------------- Stage 1 ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= in_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      p[i] = signed'(p_r[i]);
    end
    rx = D1'(p[2]) - D1'(p[0]);
    ry = D1'(p[3]) - D1'(p[1]);
    sx = D1'(p[6]) - D1'(p[4]);
    sy = D1'(p[7]) - D1'(p[5]);
    wx = D1'(p[4]) - D1'(p[0]);
    wy = D1'(p[5]) - D1'(p[1]);
    e02 = (p[0] == p[4]) && (p[1] == p[5]);
    e03 = (p[0] == p[6]) && (p[1] == p[7]);
    e12 = (p[2] == p[4]) && (p[3] == p[5]);
    e13 = (p[2] == p[6]) && (p[3] == p[7]);
    amaxx = (p[0] > p[2]) ? p[0] : p[2];
    aminx = (p[0] < p[2]) ? p[0] : p[2];
    amaxy = (p[1] > p[3]) ? p[1] : p[3];
    aminy = (p[1] < p[3]) ? p[1] : p[3];
    bmaxx = (p[4] > p[6]) ? p[4] : p[6];
    bminx = (p[4] < p[6]) ? p[4] : p[6];
    bmaxy = (p[5] > p[7]) ? p[5] : p[7];
    bminy = (p[5] < p[7]) ? p[5] : p[7];
    // Collinear runs are ordered along y only when both segments are vertical.
    ax  = (p[0] == p[2]) && (p[4] == p[6]);
    ka0 = ax ? p[1] : p[0];
    ka1 = ax ? p[3] : p[2];
    kb0 = ax ? p[5] : p[4];
    kb1 = ax ? p[7] : p[6];
    a_swap = !(ka0 <= ka1);
    b_swap = !(kb0 <= kb1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r     <= {wy, wx, sy, sx, ry, rx};
      same2_r  <= (e02 && e13) || (e03 && e12);
      share2_r <= e02 || e03 || e12 || e13;
      kb2_r    <= !(e02 || e03);
      dis2_r   <= (amaxx < bminx) || (bmaxx < aminx) || (amaxy < bminy) || (bmaxy < aminy);
      pa2_r    <= p_r[3:0];
      ord2_r   <= {b_swap ? p_r[5:4] : p_r[7:6], b_swap ? p_r[7:6] : p_r[5:4],
                   a_swap ? p_r[1:0] : p_r[3:2], a_swap ? p_r[3:2] : p_r[1:0]};
      key2_r   <= {b_swap ? kb0 : kb1, b_swap ? kb1 : kb0,
                   a_swap ? ka0 : ka1, a_swap ? ka1 : ka0};
    end
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    as_k = signed'(key2_r[0]);
    ae_k = signed'(key2_r[1]);
    bs_k = signed'(key2_r[2]);
    be_k = signed'(key2_r[3]);
    s_is_a = as_k >= bs_k;
    e_is_a = ae_k <= be_k;
    lo = s_is_a ? as_k : bs_k;
    hi = e_is_a ? ae_k : be_k;
    whole = ((lo == as_k) && (hi == ae_k)) || ((lo == bs_k) && (hi == be_k));
    cp = '0;
    ck = KIND_NONE;
    if (lo == hi) begin
      ck = KIND_POINT_OVERLAP;
      cp[1:0] = s_is_a ? ord2_r[1:0] : ord2_r[5:4];
    end else if (lo < hi) begin
      ck = whole ? KIND_CONTAINS_LINE : KIND_OVERLAP;
      cp[1:0] = s_is_a ? ord2_r[1:0] : ord2_r[5:4];
      cp[3:2] = e_is_a ? ord2_r[3:2] : ord2_r[7:6];
    end
    // Index map of d2_r: rx, ry, sx, sy, wx, wy.
    m[0] = PW'(signed'(d2_r[0])) * PW'(signed'(d2_r[3]));
    m[1] = PW'(signed'(d2_r[1])) * PW'(signed'(d2_r[2]));
    m[2] = PW'(signed'(d2_r[0])) * PW'(signed'(d2_r[5]));
    m[3] = PW'(signed'(d2_r[1])) * PW'(signed'(d2_r[4]));
    m[4] = PW'(signed'(d2_r[2])) * PW'(signed'(d2_r[5]));
    m[5] = PW'(signed'(d2_r[3])) * PW'(signed'(d2_r[4]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r     <= m;
      ck3_r    <= ck;
      cp3_r    <= cp;
      same3_r  <= same2_r;
      share3_r <= share2_r;
      kb3_r    <= kb2_r;
      dis3_r   <= dis2_r;
      pa3_r    <= pa2_r;
      rx3_r    <= d2_r[0];
      ry3_r    <= d2_r[1];
    end
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    den3 = DW'(signed'(m3_r[0])) - DW'(signed'(m3_r[1]));
    c13  = DW'(signed'(m3_r[2])) - DW'(signed'(m3_r[3]));
    c23  = DW'(signed'(m3_r[4])) - DW'(signed'(m3_r[5]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den4_r   <= den3;
      c14_r    <= c13;
      c24_r    <= c23;
      ck4_r    <= ck3_r;
      cp4_r    <= cp3_r;
      same4_r  <= same3_r;
      share4_r <= share3_r;
      kb4_r    <= kb3_r;
      dis4_r   <= dis3_r;
      pa4_r    <= pa3_r;
      rx4_r    <= rx3_r;
      ry4_r    <= ry3_r;
    end
  end

  // ---------------- Stage 4 ----------------
  // The t numerator is the negated second cross term, the u numerator the negated
  // first; both flip sign with the divisor so that the divisor is positive.
  always_comb begin
    den4s = signed'(den4_r);
    c14s  = signed'(c14_r);
    c24s  = signed'(c24_r);
    dneg4 = den4s[DW-1];
    dabs4 = dneg4 ? -den4s : den4s;
    tn4   = dneg4 ? c24s : -c24s;
    un4   = dneg4 ? c14s : -c14s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dabs5_r  <= dabs4;
      tn5_r    <= tn4;
      un5_r    <= un4;
      dz5_r    <= (den4_r == '0);
      col5_r   <= (c14_r == '0) && (c24_r == '0);
      ck5_r    <= ck4_r;
      cp5_r    <= cp4_r;
      same5_r  <= same4_r;
      share5_r <= share4_r;
      kb5_r    <= kb4_r;
      dis5_r   <= dis4_r;
      pa5_r    <= pa4_r;
      rx5_r    <= rx4_r;
      ry5_r    <= ry4_r;
    end
  end

  // ---------------- Stage 5 ----------------
  always_comb begin
    dabs5  = signed'(dabs5_r);
    tn5    = signed'(tn5_r);
    un5    = signed'(un5_r);
    in_rng = !tn5[DW-1] && (tn5 <= dabs5) && !un5[DW-1] && (un5 <= dabs5);
    on_end = (tn5 == '0) || (tn5 == dabs5) || (un5 == '0) || (un5 == dabs5);
    ctl5.kind    = KIND_NONE;
    ctl5.use_div = 1'b0;
    pts5 = '0;
    if (same5_r) begin
      ctl5.kind = KIND_SAME_LINE;
      pts5 = pa5_r;
    end else if (dis5_r) begin
      ctl5.kind = KIND_NONE;
    end else if (dz5_r) begin
      if (col5_r) begin
        ctl5.kind = ck5_r;
        pts5 = cp5_r;
      end
    end else if (share5_r) begin
      ctl5.kind = KIND_POINT_OVERLAP;
      pts5[1:0] = kb5_r ? pa5_r[3:2] : pa5_r[1:0];
    end else if (in_rng) begin
      ctl5.kind    = on_end ? KIND_CONTAINS_POINT : KIND_INTERSECTION;
      ctl5.use_div = 1'b1;
    end
    mxa = PXW'(signed'(pa5_r[0])) * PXW'(dabs5);
    mya = PXW'(signed'(pa5_r[1])) * PXW'(dabs5);
    mxb = PXW'(tn5) * PXW'(signed'(rx5_r));
    myb = PXW'(tn5) * PXW'(signed'(ry5_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl6_r  <= ctl5;
      pts6_r  <= pts5;
      mxa6_r  <= mxa;
      mxb6_r  <= mxb;
      mya6_r  <= mya;
      myb6_r  <= myb;
      dabs6_r <= dabs5_r;
    end
  end

  // ---------------- Stage 6 ----------------
  always_comb begin
    sumx6 = NW'(signed'(mxa6_r)) + NW'(signed'(mxb6_r));
    sumy6 = NW'(signed'(mya6_r)) + NW'(signed'(myb6_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl7_r  <= ctl6_r;
      pts7_r  <= pts6_r;
      sumx7_r <= sumx6;
      sumy7_r <= sumy6;
      dabs7_r <= dabs6_r;
    end
  end

  // ---------------- Stage 7 ----------------
  always_comb begin
    magx = sumx7_r[NW-1] ? (NW'(0) - sumx7_r) : sumx7_r;
    magy = sumy7_r[NW-1] ? (NW'(0) - sumy7_r) : sumy7_r;
  end

  assign valid_o = v7_r;
  assign ctl_o   = ctl7_r;
  assign pts_o   = pts7_r;
  assign neg_x_o = sumx7_r[NW-1];
  assign neg_y_o = sumy7_r[NW-1];
  assign mag_x_o = MW'(magx) << FRAC_BITS;
  assign mag_y_o = MW'(magy) << FRAC_BITS;
  assign den_o   = dabs7_r;

endmodule

>>> rtl/sic_div.sv
// Pipelined restoring divider for the crossing point: one quotient bit per stage.
// The upper numerator bits must already be below the divisor. Depends on sic_pkg.
module sic_div
  import sic_pkg::*;
#(
  parameter int DW = 35,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num_hi,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] z_r   [QW];
  logic [DW-1:0] d_r   [QW];

  // Numerator bits shift out of the top of z while quotient bits shift in below.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [QW-1:0] z_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign r_in = num_hi;
      assign z_in = num_lo;
      assign d_in = den;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign z_in = z_r[k-1];
      assign d_in = d_r[k-1];
    end

    always_comb begin
      t       = {r_in, z_in[QW-1]};
      ge      = t >= {1'b0, d_in};
      rem_nxt = ge ? DW'(t - {1'b0, d_in}) : DW'(t);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        z_r[k]   <= {z_in[QW-2:0], ge};
        d_r[k]   <= d_in;
      end
    end
  end

  assign quo = z_r[QW-1];

endmodule

>>> verif/tb_segment_intersection_classifier_top.sv
// Testbench for the segment intersection classifier: drives segment pairs over the input
// stream, predicts kind and points in Q16.16, and compares every result transfer in order.
// Depends on sic_pkg and segment_intersection_classifier_top.
module tb_segment_intersection_classifier_top;
  import sic_pkg::*;

  localparam int CB = 16;
  localparam int FB = 16;
  localparam int NUM_RANDOM = 800;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] fx, fy, sx, sy;
  } meet_t;

  typedef struct {
    logic [8*CB-1:0] segs;
    logic            known;
    meet_t           res;
  } row_t;

  logic            clk, rst_n;
  logic            in_tvalid, in_tready;
  logic [8*CB-1:0] in_tdata;
  logic            out_tvalid, out_tready;
  logic [127:0]    out_tdata;
  logic [2:0]      out_tuser;

  meet_t  pending_meets[$];
  int     mismatches;
  bit     sending_done;
  bit     long_hold;

  segment_intersection_classifier_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] sat_fix(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] q_of(longint c);
    return sat_fix(c * (longint'(1) << FB));
  endfunction

  // Point coordinate a + tn*r/den in fixed point, truncated toward zero (den > 0).
  function automatic logic [31:0] cross_coord(longint a, longint tn, longint r, longint den);
    logic signed [127:0] num, q;
    num = (128'(signed'(a)) * den + 128'(signed'(tn)) * r) <<< FB;
    q = num / 128'(signed'(den));
    if (q > 128'sd2147483647) return 32'h7fffffff;
    if (q < -128'sd2147483648) return 32'h80000000;
    return q[31:0];
  endfunction

  function automatic meet_t classify_pair(logic [8*CB-1:0] segs);
    longint p[4][2];
    meet_t m;
    longint rx, ry, sx, sy, wx, wy, den, tn, un, lo, hi;
    int ax, sa, ea, sb, eb, s, e, k;
    bit col, whole, share;
    m = '0;
    m.kind = KIND_NONE;
    for (int i = 0; i < 4; i++) begin
      p[i][0] = longint'(signed'(segs[(2*i)*CB +: CB]));
      p[i][1] = longint'(signed'(segs[(2*i+1)*CB +: CB]));
    end
    if ((p[0][0] == p[2][0] && p[0][1] == p[2][1] && p[1][0] == p[3][0] && p[1][1] == p[3][1]) ||
        (p[0][0] == p[3][0] && p[0][1] == p[3][1] && p[1][0] == p[2][0] && p[1][1] == p[2][1]))
    begin
      m.kind = KIND_SAME_LINE;
      m.fx = q_of(p[0][0]); m.fy = q_of(p[0][1]);
      m.sx = q_of(p[1][0]); m.sy = q_of(p[1][1]);
      return m;
    end
    if ((p[0][0] > p[1][0] ? p[0][0] : p[1][0]) < (p[2][0] < p[3][0] ? p[2][0] : p[3][0]) ||
        (p[2][0] > p[3][0] ? p[2][0] : p[3][0]) < (p[0][0] < p[1][0] ? p[0][0] : p[1][0]) ||
        (p[0][1] > p[1][1] ? p[0][1] : p[1][1]) < (p[2][1] < p[3][1] ? p[2][1] : p[3][1]) ||
        (p[2][1] > p[3][1] ? p[2][1] : p[3][1]) < (p[0][1] < p[1][1] ? p[0][1] : p[1][1]))
      return m;
    rx = p[1][0] - p[0][0]; ry = p[1][1] - p[0][1];
    sx = p[3][0] - p[2][0]; sy = p[3][1] - p[2][1];
    wx = p[2][0] - p[0][0]; wy = p[2][1] - p[0][1];
    den = rx * sy - ry * sx;
    if (den == 0) begin
      col = (rx * wy - ry * wx == 0) && (sx * wy - sy * wx == 0);
      if (!col) return m;
      ax = (p[0][0] == p[1][0] && p[2][0] == p[3][0]) ? 1 : 0;
      sa = p[0][ax] <= p[1][ax] ? 0 : 1; ea = 1 - sa;
      sb = p[2][ax] <= p[3][ax] ? 2 : 3; eb = 5 - sb;
      s = p[sa][ax] >= p[sb][ax] ? sa : sb;
      e = p[ea][ax] <= p[eb][ax] ? ea : eb;
      lo = p[s][ax]; hi = p[e][ax];
      if (lo == hi) begin
        m.kind = KIND_POINT_OVERLAP;
        m.fx = q_of(p[s][0]); m.fy = q_of(p[s][1]);
      end else if (lo < hi) begin
        whole = (lo == p[sa][ax] && hi == p[ea][ax]) || (lo == p[sb][ax] && hi == p[eb][ax]);
        m.kind = whole ? KIND_CONTAINS_LINE : KIND_OVERLAP;
        m.fx = q_of(p[s][0]); m.fy = q_of(p[s][1]);
        m.sx = q_of(p[e][0]); m.sy = q_of(p[e][1]);
      end
      return m;
    end
    share = 0;
    for (int i = 0; i < 2; i++)
      for (int j = 2; j < 4; j++)
        if (p[i][0] == p[j][0] && p[i][1] == p[j][1]) share = 1;
    if (share) begin
      k = ((p[0][0] == p[2][0] && p[0][1] == p[2][1]) ||
           (p[0][0] == p[3][0] && p[0][1] == p[3][1])) ? 0 : 1;
      m.kind = KIND_POINT_OVERLAP;
      m.fx = q_of(p[k][0]); m.fy = q_of(p[k][1]);
      return m;
    end
    tn = wx * sy - wy * sx;
    un = wx * ry - wy * rx;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
      m.kind = (tn == 0 || tn == den || un == 0 || un == den) ?
               KIND_CONTAINS_POINT : KIND_INTERSECTION;
      m.fx = cross_coord(p[0][0], tn, rx, den);
      m.fy = cross_coord(p[0][1], tn, ry, den);
    end
    return m;
  endfunction

  function automatic logic [8*CB-1:0] pack_segs(int c[8]);
    logic [8*CB-1:0] v;
    for (int i = 0; i < 8; i++) v[i*CB +: CB] = c[i][CB-1:0];
    return v;
  endfunction

  function automatic int rnd_coord(int span);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3)) :
                                       -32768 + int'($urandom_range(0, 3));
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  // Random pair shaped toward crossings, shared endpoints, collinear overlaps and same lines.
  function automatic logic [8*CB-1:0] random_pair();
    int c[8];
    int dx, dy, t0, t1, t2, t3;
    for (int i = 0; i < 8; i++) c[i] = rnd_coord(40);
    case ($urandom_range(0, 5))
      0: begin
        c[4] = c[0]; c[5] = c[1];
      end
      1: begin
        dx = int'($urandom_range(0, 20)) - 10; dy = int'($urandom_range(0, 20)) - 10;
        t0 = int'($urandom_range(0, 8)) - 4; t1 = int'($urandom_range(0, 8)) - 4;
        t2 = int'($urandom_range(0, 8)) - 4; t3 = int'($urandom_range(0, 8)) - 4;
        c[0] = t0 * dx; c[1] = t0 * dy; c[2] = t1 * dx; c[3] = t1 * dy;
        c[4] = t2 * dx; c[5] = t2 * dy; c[6] = t3 * dx; c[7] = t3 * dy;
      end
      2: begin
        c[4] = c[2]; c[5] = c[3]; c[6] = c[0]; c[7] = c[1];
      end
      default: ;
    endcase
    return pack_segs(c);
  endfunction

  row_t directed[$];

  function automatic row_t mk(int a0, int a1, int a2, int a3, int b0, int b1, int b2, int b3,
                              bit known = 0, kind_t kd = KIND_NONE,
                              int fx = 0, int fy = 0, int sx = 0, int sy = 0);
    row_t r;
    int c[8];
    c = '{a0, a1, a2, a3, b0, b1, b2, b3};
    r.segs = pack_segs(c);
    r.known = known;
    r.res.kind = kd;
    r.res.fx = fx; r.res.fy = fy; r.res.sx = sx; r.res.sy = sy;
    return r;
  endfunction

  // Valid drops only when an idle gap follows, so back-to-back transfers keep it high.
  task automatic send_pair(logic [8*CB-1:0] segs, bit no_gap = 0);
    int gap;
    gap = $urandom_range(0, 14);
    if (no_gap || $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= segs;
    do @(posedge clk); while (!in_tready);
    pending_meets.push_back(classify_pair(segs));
  endtask

  task automatic check_meet(meet_t exp_m, meet_t got);
    if (exp_m !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected kind %0d %h %h %h %h, got kind %0d %h %h %h %h",
                 exp_m.kind, exp_m.fx, exp_m.fy, exp_m.sx, exp_m.sy,
                 got.kind, got.fx, got.fy, got.sx, got.sy);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off so the pipeline fills up.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 0;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    meet_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = kind_t'(out_tuser);
      got.fx = out_tdata[31:0];  got.fy = out_tdata[63:32];
      got.sx = out_tdata[95:64]; got.sy = out_tdata[127:96];
      if (pending_meets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer, kind %0d", out_tuser);
      end else begin
        check_meet(pending_meets.pop_front(), got);
      end
    end
  end

  initial begin
    int waited;
    mismatches = 0;
    long_hold = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(mk(0, 0, 10, 10, 0, 0, 10, 10, 1, KIND_SAME_LINE, 0, 0, 655360, 655360));
    directed.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768,
                          1, KIND_SAME_LINE, 32'h80000000, 32'h80000000,
                          32'h7fff0000, 32'h7fff0000));
    directed.push_back(mk(0, 0, 1, 1, 5, 5, 6, 7, 1));
    directed.push_back(mk(0, 0, 10, 0, 0, 1, 10, 1, 1));
    directed.push_back(mk(0, 0, 10, 0, 0, 0, 10, 1));
    directed.push_back(mk(0, 0, 4, 0, 4, 0, 8, 0, 1, KIND_POINT_OVERLAP, 262144, 0));
    directed.push_back(mk(0, 0, 10, 0, 2, 0, 5, 0, 1, KIND_CONTAINS_LINE,
                          131072, 0, 327680, 0));
    directed.push_back(mk(0, 0, 10, 0, 5, 0, 15, 0, 1, KIND_OVERLAP, 327680, 0, 655360, 0));
    directed.push_back(mk(0, 0, 0, 10, 0, 12, 0, 4, 1, KIND_OVERLAP, 0, 262144, 0, 655360));
    directed.push_back(mk(0, 0, 0, 10, 0, 11, 0, 20, 1));
    directed.push_back(mk(3, 3, 3, 3, 0, 0, 6, 6, 1, KIND_POINT_OVERLAP, 196608, 196608));
    directed.push_back(mk(3, 3, 3, 3, 3, 3, 3, 3, 1, KIND_SAME_LINE,
                          196608, 196608, 196608, 196608));
    directed.push_back(mk(0, 0, 10, 10, 0, 0, 10, -3, 1, KIND_POINT_OVERLAP, 0, 0));
    directed.push_back(mk(0, 0, 10, 10, 3, 20, 10, 10, 1, KIND_POINT_OVERLAP, 655360, 655360));
    directed.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0, 1, KIND_INTERSECTION, 327680, 327680));
    directed.push_back(mk(0, 0, 10, 0, 5, 0, 5, 5, 1, KIND_CONTAINS_POINT, 327680, 0));
    directed.push_back(mk(0, 0, 3, 1, 1, 0, 0, 2));
    directed.push_back(mk(0, 0, -3, 1, -1, 0, 0, 2));
    directed.push_back(mk(0, 0, 10, 10, 0, 10, 4, 6));
    directed.push_back(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
    directed.push_back(mk(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767));
    directed.push_back(mk(-1, -1, -1, -1, -1, -1, 1, 1));

    foreach (directed[i]) begin
      send_pair(directed[i].segs);
      if (directed[i].known) check_meet(directed[i].res, pending_meets[$]);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) long_hold = 1;
      send_pair(random_pair(), long_hold);
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending_meets.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * (8 + CB + FB)) @(posedge clk);
    if (mismatches == 0 && pending_meets.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sic_pkg.sv
rtl/sic_front.sv
rtl/sic_div.sv
rtl/segment_intersection_classifier_top.sv
verif/tb_segment_intersection_classifier_top.sv
